@@ src/ovs_pkg.sv @@
// Shared constants, types and coefficient table of the 4x polyphase oversampler.
package ovs_pkg;

  localparam int RATIO       = 4;
  localparam int PHASE_TAPS  = 16;
  localparam int SAMPLE_BITS = 24;

  localparam int PROTO_LEN   = 64;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 16;
  localparam int LINE_LEN    = RATIO * PHASE_TAPS;
  localparam int RAM_DEPTH   = LINE_LEN + PHASE_TAPS;
  localparam int ADDR_BITS   = $clog2(RAM_DEPTH);
  localparam int PH_BITS     = $clog2(RATIO);
  localparam int TAP_BITS    = $clog2(PHASE_TAPS);
  localparam int CIDX_BITS   = $clog2(LINE_LEN);
  localparam int PIDX_BITS   = $clog2(PROTO_LEN);
  localparam int SCOEF_BITS  = COEF_BITS + $clog2(RATIO) + 1;
  localparam int PROD_BITS   = SAMPLE_BITS + SCOEF_BITS;
  localparam int ACC_BITS    = PROD_BITS + $clog2(LINE_LEN);

  localparam logic ACT_INTERP = 1'b0;
  localparam logic ACT_DECIM  = 1'b1;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam coef_t PROTO_Q [PROTO_LEN] = '{
    -16'sd7,     16'sd20,     -16'sd46,    16'sd85,
    -16'sd144,   16'sd223,    -16'sd321,   16'sd439,
    -16'sd570,   16'sd708,    -16'sd845,   16'sd963,
    -16'sd1055,  16'sd1101,   -16'sd1094,  16'sd1029,
    -16'sd891,   16'sd682,    -16'sd400,   16'sd46,
    16'sd354,    -16'sd839,   16'sd1376,   -16'sd1960,
    16'sd2582,   -16'sd3244,  16'sd3932,   -16'sd4640,
    16'sd5354,   -16'sd6075,  16'sd6790,   -16'sd7491,
    16'sd8179,   -16'sd8841,  16'sd9483,   -16'sd10093,
    16'sd10676,  -16'sd11226, 16'sd11744,  -16'sd12229,
    16'sd12681,  -16'sd13101, 16'sd13487,  -16'sd13841,
    16'sd14169,  -16'sd14464, 16'sd14732,  -16'sd14975,
    16'sd15191,  -16'sd15388, 16'sd15565,  -16'sd15722,
    16'sd15860,  -16'sd15984, 16'sd16096,  -16'sd16194,
    16'sd16286,  -16'sd16364, 16'sd16437,  -16'sd16502,
    16'sd16561,  -16'sd16614, 16'sd16666,  -16'sd16712
  };

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [SAMPLE_BITS-1:0] over_0;
    logic signed [SAMPLE_BITS-1:0] over_1;
    logic signed [SAMPLE_BITS-1:0] over_2;
    logic signed [SAMPLE_BITS-1:0] over_3;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_EMIT
  } ovs_state_t;

  typedef struct packed {
    logic                          en;
    logic [ADDR_BITS-1:0]          addr;
    logic signed [SAMPLE_BITS-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_flags_t;

  typedef struct packed {
    mac_flags_t           flags;
    logic                 scale;
    logic [CIDX_BITS-1:0] cidx;
  } mac_op_t;

  typedef struct packed {
    logic load;
    logic last;
  } emit_t;

  // prototype coefficient, zero past the table
  function automatic coef_t proto_coef(input logic [CIDX_BITS-1:0] idx);
    logic [PIDX_BITS-1:0] i;
    i = PIDX_BITS'(idx);
    if (32'(idx) < PROTO_LEN) begin
      return PROTO_Q[i];
    end
    return '0;
  endfunction

endpackage

@@ src/polyphase_oversampler_4x.sv @@
// Top level of the 4x polyphase oversampler: sequencer, delay-line memory, MAC, output register.
//
// Input channel in_valid/in_stall/in_data carries one transaction per item: action 0
// interpolates sample_in into four results, action 1 decimates over_0..over_3 into one.
// Results leave on out_valid/out_stall/out_data; last marks the final result of an item.
// All delay-line samples sit in one single-port memory; one multiplier handles one tap
// a cycle, so an item costs one memory write per sample plus one read per tap.
// Interpolate: 1 write, then per result 16 reads that pass through the MAC pipeline.
// Decimate: 4 writes, then 64 reads that pass through the MAC pipeline into one result.
// Receiver stalls delay the hand-off of results.
// A new transaction is accepted once the last result has moved into the output
// register, even while that result is still stalled there.
// A stalled output register holds its result; the sequencer then waits before loading
// the next result of the same item.
// Synchronous reset (rst_n low) clears all delay lines to zero at once through valid
// flags, zeroes both line positions and empties the output register; no clearing pass.
module polyphase_oversampler_4x
  import ovs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ram_wr_t                       ram_wr;
  ram_rd_t                       ram_rd;
  mac_op_t                       mac_op;
  emit_t                         emit;
  logic                          mac_done;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] mac_result;
  logic                          out_free;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r, out_data_nxt;

  assign out_free = !out_valid_r || !out_stall;

  ovs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_free (out_free),
    .mac_done (mac_done),
    .ram_wr   (ram_wr),
    .ram_rd   (ram_rd),
    .mac_op   (mac_op),
    .emit     (emit)
  );

  ovs_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  ovs_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (mac_op),
    .rd_data (rd_data),
    .take    (emit.load),
    .done    (mac_done),
    .result  (mac_result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.sample_out = mac_result;
      out_data_nxt.last     = emit.last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/ovs_ram.sv @@
// Delay-line memory: decimation phase lines followed by the interpolation line.
module ovs_ram
  import ovs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  ram_wr_t                       wr,
  input  ram_rd_t                       rd,
  output logic signed [SAMPLE_BITS-1:0] rd_data
);

  logic signed [SAMPLE_BITS-1:0] mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0]          valid_r;
  logic [RAM_DEPTH-1:0]          valid_nxt;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd.en) begin
        rd_vld_r <= valid_r[rd.addr];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ src/ovs_mac.sv @@
// Multiply-accumulate pipeline with round-half-up and saturation to the sample range.
module ovs_mac
  import ovs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_op_t                       op,
  input  logic signed [SAMPLE_BITS-1:0] rd_data,
  input  logic                          take,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int QB = ACC_BITS + 1 - COEF_FRAC;
  localparam logic signed [SCOEF_BITS-1:0] RATIO_S = SCOEF_BITS'(RATIO);
  localparam logic signed [ACC_BITS:0] RND_HALF = (ACC_BITS + 1)'(1) << (COEF_FRAC - 1);
  localparam logic signed [QB-1:0] Q_HI = {{(QB - SAMPLE_BITS + 1){1'b0}},
                                           {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [QB-1:0] Q_LO = {{(QB - SAMPLE_BITS + 1){1'b1}},
                                           {(SAMPLE_BITS - 1){1'b0}}};

  mac_flags_t                    fl_s1_r, fl_s2_r;
  logic signed [SCOEF_BITS-1:0]  coef_s1_r, coef_s1_nxt;
  logic signed [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic signed [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic                          done_r, done_nxt;
  logic signed [ACC_BITS:0]      rnd;
  logic signed [QB-1:0]          q;

  always_comb begin
    coef_s1_nxt = SCOEF_BITS'(proto_coef(op.cidx));
    if (op.scale) begin
      coef_s1_nxt = coef_s1_nxt * RATIO_S;
    end
    prod_nxt = rd_data * coef_s1_r;
    acc_nxt  = acc_r;
    if (fl_s2_r.vld) begin
      acc_nxt = fl_s2_r.first ? ACC_BITS'(prod_r) : acc_r + ACC_BITS'(prod_r);
    end
    done_nxt = done_r;
    if (take) begin
      done_nxt = 1'b0;
    end else if (fl_s2_r.vld && fl_s2_r.last) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    coef_s1_r <= coef_s1_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_s1_r <= '0;
      fl_s2_r <= '0;
      done_r  <= 1'b0;
    end else begin
      fl_s1_r <= op.flags;
      fl_s2_r <= fl_s1_r;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    rnd = (ACC_BITS + 1)'(acc_r) + RND_HALF;
    q   = QB'(rnd >>> COEF_FRAC);
    if (q > Q_HI) begin
      result = SAMPLE_BITS'(Q_HI);
    end else if (q < Q_LO) begin
      result = SAMPLE_BITS'(Q_LO);
    end else begin
      result = SAMPLE_BITS'(q);
    end
  end

  assign done = done_r;

endmodule

@@ src/ovs_ctrl.sv @@
// Sequencer: sample writes, tap reads, result hand-off and delay-line positions.
module ovs_ctrl
  import ovs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     out_free,
  input  logic     mac_done,
  output ram_wr_t  ram_wr,
  output ram_rd_t  ram_rd,
  output mac_op_t  mac_op,
  output emit_t    emit
);

  localparam logic [PH_BITS-1:0]  PH_LAST  = PH_BITS'(RATIO - 1);
  localparam logic [TAP_BITS-1:0] TAP_LAST = TAP_BITS'(PHASE_TAPS - 1);

  ovs_state_t          state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [PH_BITS-1:0]  ph_r, ph_nxt;
  logic [TAP_BITS-1:0] tap_r, tap_nxt;
  logic [TAP_BITS-1:0] ipos_r, ipos_nxt;
  logic [TAP_BITS-1:0] dpos_r, dpos_nxt;
  logic                interp;
  logic [TAP_BITS-1:0] pos;
  logic [TAP_BITS:0]   slot_sum;
  logic [TAP_BITS-1:0] slot;
  logic [ADDR_BITS-1:0] phase_base;
  logic signed [SAMPLE_BITS-1:0] over_sel;
  logic                go;

  assign interp     = (item_r.action == ACT_INTERP);
  assign pos        = interp ? ipos_r : dpos_r;
  assign phase_base = ADDR_BITS'(ph_r) * ADDR_BITS'(PHASE_TAPS);
  assign go         = mac_done && out_free;

  always_comb begin
    slot_sum = (TAP_BITS + 1)'(pos) + (TAP_BITS + 1)'(tap_r);
    if (slot_sum >= (TAP_BITS + 1)'(PHASE_TAPS)) begin
      slot_sum = slot_sum - (TAP_BITS + 1)'(PHASE_TAPS);
    end
    slot = slot_sum[TAP_BITS-1:0];
  end

  always_comb begin
    case (ph_r)
      PH_BITS'(0): over_sel = item_r.over_0;
      PH_BITS'(1): over_sel = item_r.over_1;
      PH_BITS'(2): over_sel = item_r.over_2;
      PH_BITS'(3): over_sel = item_r.over_3;
      default:     over_sel = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (interp || ph_r == PH_LAST) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (tap_r == TAP_LAST && (interp || ph_r == PH_LAST)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (go) begin
          state_nxt = (interp && ph_r != PH_LAST) ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_wr      = '0;
    ram_rd      = '0;
    mac_op      = '0;
    emit        = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_WRITE: begin
        ram_wr.en = 1'b1;
        if (interp) begin
          ram_wr.addr = ADDR_BITS'(LINE_LEN) + ADDR_BITS'(ipos_r);
          ram_wr.data = item_r.sample_in;
        end else begin
          ram_wr.addr = phase_base + ADDR_BITS'(dpos_r);
          ram_wr.data = over_sel;
        end
      end
      ST_READ: begin
        ram_rd.en = 1'b1;
        if (interp) begin
          ram_rd.addr        = ADDR_BITS'(LINE_LEN) + ADDR_BITS'(slot);
          mac_op.flags.first = (tap_r == '0);
          mac_op.flags.last  = (tap_r == TAP_LAST);
        end else begin
          ram_rd.addr        = phase_base + ADDR_BITS'(slot);
          mac_op.flags.first = (tap_r == '0) && (ph_r == '0);
          mac_op.flags.last  = (tap_r == TAP_LAST) && (ph_r == PH_LAST);
        end
        mac_op.flags.vld = 1'b1;
        mac_op.scale     = interp;
        mac_op.cidx      = CIDX_BITS'(tap_r) * CIDX_BITS'(RATIO) + CIDX_BITS'(ph_r);
      end
      ST_EMIT: begin
        emit.load = go;
        emit.last = !interp || ph_r == PH_LAST;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // counters and positions
  always_comb begin
    item_nxt = item_r;
    ph_nxt   = ph_r;
    tap_nxt  = tap_r;
    ipos_nxt = ipos_r;
    dpos_nxt = dpos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          ph_nxt   = '0;
          tap_nxt  = '0;
        end
      end
      ST_WRITE: begin
        if (!interp) begin
          ph_nxt = (ph_r == PH_LAST) ? '0 : ph_r + 1'b1;
        end
      end
      ST_READ: begin
        if (interp) begin
          tap_nxt = (tap_r == TAP_LAST) ? '0 : tap_r + 1'b1;
        end else if (ph_r == PH_LAST) begin
          ph_nxt  = '0;
          tap_nxt = (tap_r == TAP_LAST) ? '0 : tap_r + 1'b1;
        end else begin
          ph_nxt = ph_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (go) begin
          if (interp) begin
            if (ph_r != PH_LAST) begin
              ph_nxt = ph_r + 1'b1;
            end else begin
              ph_nxt   = '0;
              ipos_nxt = (ipos_r == '0) ? TAP_LAST : ipos_r - 1'b1;
            end
          end else begin
            dpos_nxt = (dpos_r == '0) ? TAP_LAST : dpos_r - 1'b1;
          end
        end
      end
      default: begin
        ph_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      tap_r   <= '0;
      ipos_r  <= '0;
      dpos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      tap_r   <= tap_nxt;
      ipos_r  <= ipos_nxt;
      dpos_r  <= dpos_nxt;
    end
  end

  a_no_wr_rd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr.en && ram_rd.en))
    else $error("memory write and read in the same cycle");

  a_done_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mac_done) |-> state_r == ST_EMIT)
    else $error("accumulation finished outside the emit state");

  a_emit_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |=> !mac_done)
    else $error("result done flag not cleared after hand-off");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> $stable(ipos_r) && $stable(dpos_r))
    else $error("delay-line position moved at transaction start");

endmodule
